### hw/rtl/stc_pkg.sv
// stc_pkg: command, status and state codes for the stack calculator
// depends on nothing
`default_nettype none
package stc_pkg;
  typedef enum logic [2:0] {
    FN_PUSH = 3'd0, FN_POP = 3'd1, FN_PEEKT = 3'd2, FN_PEEKB = 3'd3,
    FN_ADD = 3'd4, FN_SUB = 3'd5, FN_MUL = 3'd6, FN_DIV = 3'd7
  } func_e;
  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_INDEX = 3'd2, ST_DIVZ = 3'd3, ST_FULL = 3'd4
  } status_e;
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD1 = 7'b0000010, S_RD2 = 7'b0000100,
    S_MUL = 7'b0001000, S_DIV = 7'b0010000, S_WB = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;
  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } alu_rsp_t;
endpackage
`default_nettype wire

### hw/rtl/stc_muldiv.sv
// stc_muldiv: shared iterative unit, 32-step shift-add multiply and
// restoring floor divide; depends on stc_pkg
`default_nettype none
module stc_muldiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stc_pkg::alu_req_t  req_i,
  output stc_pkg::alu_rsp_t  rsp_o
);
  import stc_pkg::*;
  logic        busy_q, busy_d, div_q, div_d, fix_q, fix_d, neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d, sh_q, sh_d, op_q, op_d;
  logic [32:0] trial;
  logic [31:0] qraw;
  logic [31:0] bmag, amag;

  assign bmag = req_i.b[31] ? (~req_i.b + 32'd1) : req_i.b;
  assign amag = req_i.a[31] ? (~req_i.a + 32'd1) : req_i.a;
  assign trial = {acc_q, sh_q[31]} - {1'b0, op_q};
  assign qraw = neg_q ? (~sh_q + 32'd1) : sh_q;

  always_comb begin
    busy_d = busy_q; div_d = div_q; fix_d = fix_q; neg_d = neg_q;
    cnt_d = cnt_q; acc_d = acc_q; sh_d = sh_q; op_d = op_q;
    rsp_o.done = 1'b0;
    rsp_o.res = div_q ? (qraw - {31'd0, fix_q && acc_q != 32'd0}) : acc_q;
    if (req_i.start) begin
      busy_d = 1'b1; div_d = req_i.is_div; cnt_d = 6'd0; acc_d = 32'd0;
      sh_d = req_i.is_div ? bmag : req_i.b;
      op_d = req_i.is_div ? amag : req_i.a;
      neg_d = req_i.a[31] ^ req_i.b[31];
      fix_d = req_i.a[31] ^ req_i.b[31];
    end else if (busy_q) begin
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        rsp_o.done = 1'b1;
      end else begin
        cnt_d = cnt_q + 6'd1;
        if (div_q) begin
          if (!trial[32]) begin
            acc_d = trial[31:0]; sh_d = {sh_q[30:0], 1'b1};
          end else begin
            acc_d = {acc_q[30:0], sh_q[31]}; sh_d = {sh_q[30:0], 1'b0};
          end
        end else begin
          acc_d = op_q[0] ? acc_q + sh_q : acc_q;
          sh_d = {sh_q[30:0], 1'b0};
          op_d = {1'b0, op_q[31:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= 6'd0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    div_q <= div_d; fix_q <= fix_d; neg_q <= neg_d;
    acc_q <= acc_d; sh_q <= sh_d; op_q <= op_d;
  end
endmodule
`default_nettype wire

### hw/rtl/stack_calculator_unit.sv
// stack_calculator_unit: top level, sequencer, stack memory and count
// depends on stc_pkg and stc_muldiv
//
// usage: drive func_i, push_value_i, index_i and raise start_i while busy_o
// is low; the word is taken at that edge. exactly one result word follows
// on result_o, status_o, entries_o with done_o high for one cycle; the
// receiver cannot stall, so it must sample it then.
// from accept to done: push and errors found at decode go S_RD1, S_DONE;
// pop and peek go S_RD1, S_WB, S_MUL, S_DONE; add, sub, mul, div go S_RD1,
// S_RD2, S_MUL, S_DIV (divide by zero ends here; mul and div run the 32-step
// shared loop), S_WB, S_DONE. busy_o is high from accept to the done cycle,
// so the next command is taken in the cycle after done at the earliest.
// one command at a time. stack memory has one port, read data registered.
// reset clears the entry count and the sequencer; stack contents are not
// cleared, and no clearing pass is run.
`default_nettype none
module stack_calculator_unit #(
  parameter int DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic signed [31:0] push_value_i,
  input  logic [9:0]  index_i,
  output logic        done_o,
  output logic signed [31:0] result_o,
  output logic [2:0]  status_o,
  output logic [10:0] entries_o
);
  import stc_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0] mem [DEPTH];
  state_e      st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  func_e       fn_q, fn_d;
  logic [31:0] val_q, val_d, a_q, a_d, res_q, res_d, rd_q;
  logic [9:0]  idx_q, idx_d;
  logic [2:0]  sts_q, sts_d;
  logic        we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;
  logic [CW:0] pidx;
  alu_req_t    req;
  alu_rsp_t    rsp;

  stc_muldiv u_md (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign pidx = cnt_q - {{CW{1'b0}}, 1'b1} - CW'(idx_q);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; fn_d = fn_q; val_d = val_q; idx_d = idx_q;
    a_d = a_q; res_d = res_q; sts_d = sts_q;
    we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = val_q;
    req = '0;
    unique case (st_q)
      S_IDLE: if (start_i) begin
        fn_d = func_e'(func_i); val_d = push_value_i; idx_d = index_i;
        st_d = S_RD1;
      end
      S_RD1: begin
        res_d = 32'd0; sts_d = ST_OK; st_d = S_DONE;
        unique case (fn_q) inside
          FN_PUSH: if (cnt_q == CW'(DEPTH)) sts_d = ST_FULL;
            else begin
              we = 1'b1; waddr = AW'(cnt_q); cnt_d = cnt_q + 1'b1;
            end
          FN_POP: if (cnt_q == '0) sts_d = ST_EMPTY;
            else begin re = 1'b1; raddr = AW'(cnt_q - 1'b1); st_d = S_WB; end
          FN_PEEKT, FN_PEEKB: if ({{(CW > 10 ? CW-10 : 0){1'b0}}, idx_q} >= cnt_q)
              sts_d = ST_INDEX;
            else begin
              re = 1'b1; st_d = S_WB;
              raddr = (fn_q == FN_PEEKT) ? AW'(pidx) : AW'(idx_q);
            end
          default: if (cnt_q < CW'(2)) sts_d = ST_EMPTY;
            else begin re = 1'b1; raddr = AW'(cnt_q - 1'b1); st_d = S_RD2; end
        endcase
      end
      S_RD2: begin
        a_d = rd_q;
        re = 1'b1; raddr = AW'(cnt_q - CW'(2)); st_d = S_MUL;
      end
      S_MUL: begin
        if (fn_q == FN_POP || fn_q == FN_PEEKT || fn_q == FN_PEEKB) begin
          res_d = rd_q; st_d = S_DONE;
          if (fn_q == FN_POP) cnt_d = cnt_q - 1'b1;
        end else st_d = S_DIV;
      end
      S_DIV: begin
        st_d = S_WB;
        case (fn_q)
          FN_ADD: res_d = rd_q + a_q;
          FN_SUB: res_d = rd_q - a_q;
          FN_DIV: if (a_q == 32'd0) begin sts_d = ST_DIVZ; st_d = S_DONE; end
            else req = '{start: 1'b1, is_div: 1'b1, a: a_q, b: rd_q};
          default: req = '{start: 1'b1, is_div: 1'b0, a: a_q, b: rd_q};
        endcase
      end
      S_WB: begin
        if (fn_q == FN_POP || fn_q == FN_PEEKT || fn_q == FN_PEEKB) st_d = S_MUL;
        else if (fn_q == FN_ADD || fn_q == FN_SUB || rsp.done) begin
          if (rsp.done) res_d = rsp.res;
          wdata = rsp.done ? rsp.res : res_q;
          we = 1'b1; waddr = AW'(cnt_q - CW'(2)); cnt_d = cnt_q - 1'b1;
          st_d = S_DONE;
        end
      end
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    fn_q <= fn_d; val_q <= val_d; idx_q <= idx_d; a_q <= a_d;
    res_q <= res_d; sts_q <= sts_d;
  end

  assign busy_o = (st_q != S_IDLE);
  assign done_o = (st_q == S_DONE);
  assign result_o = res_q;
  assign status_o = sts_q;
  assign entries_o = 11'(cnt_q);

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("entry count above depth");
  a_err_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> $stable(cnt_q)) else $error("error changed count");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
`endif
endmodule
`default_nettype wire
